[rtl/core/base64_byte_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Base64 byte encoder assertion macros
// Shared concurrent assertion shorthands for the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_BYTE_ENCODER_MACROS_SVH
`define BASE64_BYTE_ENCODER_MACROS_SVH

// implication checked every clock outside reset
`define B64E_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("b64e assertion failed");

// condition that must never hold outside reset
`define B64E_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("b64e assertion failed");

`endif

[rtl/core/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// Base64 encoder package
// Beat types, job format and alphabet mapping shared by the encoder blocks.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64e_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;
  } b64e_out_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } b64e_sym_t;

  typedef struct packed {
    b64e_sym_t [3:0] sym;
    logic [1:0]      last_idx;
    logic            fin;
  } b64e_job_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return 7'd65 + v7;
    end else if (v < 6'd52) begin
      return 7'd97 + v7 - 7'd26;
    end else if (v < 6'd62) begin
      return 7'd48 + v7 - 7'd52;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

[rtl/core/b64e_front.sv]
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts raw bytes, tracks the group phase and leftover bits, and splits
// each byte into a job of one to four sextets or pad symbols.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64e_pkg::b64e_in_t  in_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output b64e_pkg::b64e_job_t job_o
);
  import b64e_pkg::*;

  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;
  logic       fin;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign b          = in_data_i.data_byte;
  assign fin        = in_data_i.final_byte;

  always_comb begin
    job_o     = '0;
    job_o.fin = fin;
    phase_d   = PH_ZERO;
    carry_d   = 4'd0;
    unique case (phase_q)
      PH_ONE: begin
        job_o.sym[0].sextet = {carry_q[1:0], b[7:4]};
        if (fin) begin
          job_o.sym[1].sextet = {b[3:0], 2'b00};
          job_o.sym[2].pad    = 1'b1;
          job_o.last_idx      = 2'd2;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = PH_TWO;
          carry_d        = b[3:0];
        end
      end
      PH_TWO: begin
        job_o.sym[0].sextet = {carry_q, b[7:6]};
        job_o.sym[1].sextet = b[5:0];
        job_o.last_idx      = 2'd1;
      end
      default: begin
        job_o.sym[0].sextet = b[7:2];
        if (fin) begin
          job_o.sym[1].sextet = {b[1:0], 4'b0000};
          job_o.sym[2].pad    = 1'b1;
          job_o.sym[3].pad    = 1'b1;
          job_o.last_idx      = 2'd3;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = PH_ONE;
          carry_d        = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ZERO;
      carry_q <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short first-in first-out buffer of jobs between front end and back end.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64e_pkg::b64e_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output b64e_pkg::b64e_job_t head_o
);
  import b64e_pkg::*;

  b64e_job_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks the head job one symbol per cycle unless stalled, maps it to ASCII
// and holds the character in the output register until the beat is taken.
// ----------------------------------------------------------------------------
`include "base64_byte_encoder_macros.svh"

module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  b64e_pkg::b64e_job_t q_job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64e_pkg::b64e_out_t out_data_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  b64e_out_t  out_q;
  b64e_sym_t  sym;
  logic       out_free;
  logic       issue;
  logic       last;

  assign sym      = q_job_i.sym[idx_q];
  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = q_valid_i && out_free;
  assign last     = (idx_q == q_job_i.last_idx);
  assign pop_o    = issue && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
      if (out_free) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q.out_char    <= sym.pad ? PAD_CHAR : b64_char(sym.sextet);
      out_q.run_last    <= last;
      out_q.message_end <= last && q_job_i.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `B64E_ASSERT_IMPLY(a_end_is_run_last, clk_i, rst_ni,
                     out_valid_q && out_q.message_end, out_q.run_last)
  `B64E_ASSERT_IMPLY(a_idx_in_job, clk_i, rst_ni, q_valid_i, idx_q <= q_job_i.last_idx)
  `B64E_ASSERT_NEVER(a_no_leading_pad, clk_i, rst_ni, q_valid_i && q_job_i.sym[0].pad)

endmodule

[rtl/core/base64_byte_encoder.sv]
// ----------------------------------------------------------------------------
// Base64 byte encoder
// Streams raw bytes in and standard-alphabet Base64 characters out.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per beat, with final_byte set on the last byte
// of a message. Output channel: one ASCII character per beat; run_last marks
// the last character caused by a byte, message_end the last of a message.
// A byte yields one or two characters mid-message, and three or four
// (including '=' padding) when it closes a message on a partial group.
// A byte beat is written into the job queue, and its first character then
// goes to the output register. Throughput: one character per cycle while the
// receiver does not stall, set by the single character path in the back end.
// The front end classifies bytes into jobs, a two-entry job queue absorbs
// bursts, and bytes keep flowing while the output register holds a beat.
// Reset clears the group phase, leftover bits, queue and output valid flag.
// While the receiver stalls, the output beat holds; once the queue fills,
// in_stall_o rises until the back end frees an entry.
// ----------------------------------------------------------------------------
module base64_byte_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b64e_pkg::b64e_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64e_pkg::b64e_out_t out_data_o
);
  import b64e_pkg::*;

  b64e_job_t push_job;
  b64e_job_t head_job;
  logic      push;
  logic      full;
  logic      pop;
  logic      q_valid;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 byte encoder testbench
// Sends raw bytes grouped into messages, predicts every Base64 character,
// including '=' padding and the run_last and message_end flags, and compares
// each output beat in order against the prediction. Both channels idle and
// stall at random, except during one burst with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import b64e_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned IDLE_PERCENT   = 18;
  localparam int unsigned RANDOM_ITEMS   = 225;
  localparam int unsigned BURST_ITEMS    = 60;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } group_pos_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall_o;
  b64e_in_t  in_data;
  logic      out_valid_o;
  logic      out_stall;
  b64e_out_t out_data_o;

  logic      idle_on;
  int        mismatches;
  int        quiet_cycles;
  int        items_sent;

  string      b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  group_pos_e enc_phase;
  logic [3:0] enc_carry;
  b64e_out_t  expected_chars [$];

  base64_byte_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic b64e_out_t char_beat(input logic [6:0] ch);
    b64e_out_t beat;
    beat             = '0;
    beat.out_char    = ch;
    return beat;
  endfunction

  function automatic b64e_out_t sextet_beat(input logic [5:0] v);
    byte ch;
    ch = b64_alphabet[v];
    return char_beat(ch[6:0]);
  endfunction

  function automatic void predict_chars(input b64e_in_t beat);
    logic [7:0] b;
    b64e_out_t  tail;
    b = beat.data_byte;
    case (enc_phase)
      PH_SECOND: begin
        expected_chars.push_back(sextet_beat({enc_carry[1:0], b[7:4]}));
        if (beat.final_byte) begin
          expected_chars.push_back(sextet_beat({b[3:0], 2'b00}));
          expected_chars.push_back(char_beat(PAD_CHAR));
          enc_phase = PH_FIRST;
          enc_carry = '0;
        end else begin
          enc_phase = PH_THIRD;
          enc_carry = b[3:0];
        end
      end
      PH_THIRD: begin
        expected_chars.push_back(sextet_beat({enc_carry, b[7:6]}));
        expected_chars.push_back(sextet_beat(b[5:0]));
        enc_phase = PH_FIRST;
        enc_carry = '0;
      end
      default: begin
        expected_chars.push_back(sextet_beat(b[7:2]));
        if (beat.final_byte) begin
          expected_chars.push_back(sextet_beat({b[1:0], 4'b0000}));
          expected_chars.push_back(char_beat(PAD_CHAR));
          expected_chars.push_back(char_beat(PAD_CHAR));
          enc_phase = PH_FIRST;
          enc_carry = '0;
        end else begin
          enc_phase = PH_SECOND;
          enc_carry = {2'b00, b[1:0]};
        end
      end
    endcase
    tail             = expected_chars.pop_back();
    tail.run_last    = 1'b1;
    tail.message_end = beat.final_byte;
    expected_chars.push_back(tail);
  endfunction

  function automatic void log_mismatch(input string what, input b64e_out_t want,
                                       input b64e_out_t got);
    if (mismatches < 10) begin
      $display("%s: expected char %0d run_last %0b message_end %0b",
               what, want.out_char, want.run_last, want.message_end);
      $display("  got char %0d run_last %0b message_end %0b",
               got.out_char, got.run_last, got.message_end);
    end
    mismatches++;
  endfunction

  task automatic check_char(input b64e_out_t got);
    b64e_out_t want;
    if (expected_chars.size() == 0) begin
      log_mismatch("unexpected beat", '0, got);
    end else begin
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.run_last !== want.run_last ||
          got.message_end !== want.message_end) begin
        log_mismatch("character mismatch", want, got);
      end
    end
  endtask

  // stall the output side at random and check every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      check_char(out_data_o);
    end
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    b64e_in_t beat;
    beat.data_byte  = b;
    beat.final_byte = fin;
    while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_chars(beat);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      return 8'h00;
    end else if (sel < 20) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) begin
      send_byte(pick_byte(), i == len);
    end
  endtask

  task automatic test_single_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'h03, 1'b1);
  endtask

  task automatic test_two_byte_messages();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_group_closing_final();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_zero_bytes_mid_message();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      send_message($urandom_range(9, 1));
    end
  endtask

  task automatic test_back_to_back_burst();
    int unsigned target;
    target  = items_sent + BURST_ITEMS;
    idle_on = 1'b0;
    while (items_sent < target) begin
      send_message($urandom_range(7, 1));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned wait_cycles;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    idle_on      = 1'b1;
    mismatches   = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    enc_phase    = PH_FIRST;
    enc_carry    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_messages();
    test_two_byte_messages();
    test_group_closing_final();
    test_zero_bytes_mid_message();
    test_random_messages();
    test_back_to_back_burst();
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_chars.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      $display("%0d expected characters never arrived", expected_chars.size());
      mismatches += expected_chars.size();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
